// ===== rtl/mdr_pkg.sv =====
// Shared types and constants of the multidrop bus device receiver.
package mdr_pkg;

	localparam int unsigned WORD_W   = 9;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ID_W     = 7;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned PHASE_W  = 2;

	// Protocol phases.
	localparam logic [PHASE_W-1:0] PHASE_LISTEN  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_POLL    = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_RECEIVE = 2'd2;

	// Word prefixes placed above the device id.
	localparam logic [1:0] PREFIX_ADDR   = 2'b10;
	localparam logic [1:0] PREFIX_POLL   = 2'b11;
	localparam logic [1:0] PREFIX_SELECT = 2'b01;
	localparam logic [WORD_W-1:0] BROADCAST_WORD = 9'h100;

	// Word positions inside a message.
	localparam logic [COUNT_W-1:0] COUNT_START  = 6'd1;
	localparam logic [COUNT_W-1:0] COUNT_LENGTH = 6'd2;
	localparam logic [COUNT_W-1:0] COUNT_EXTRA  = 6'd3;

	// Reply kinds.
	localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ACK   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NACK  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEND  = 3'd4;

	localparam logic [BYTE_W-1:0] ONE_BYTE = 8'd1;
	localparam logic [ID_W-1:0]   DEVICE_ID_RESET = 7'd10;

	typedef struct packed {
		logic [WORD_W-1:0] rx_word;
		logic [BYTE_W-1:0] pending_tx_length;
	} in_item_t;

	typedef struct packed {
		logic              forward_valid;
		logic [WORD_W-1:0] forward_word;
		logic [KIND_W-1:0] reply_kind;
		logic [BYTE_W-1:0] reply_length;
		logic              message_good;
		logic              message_bad;
	} out_item_t;

endpackage

// ===== rtl/mdr_in_if.sv =====
// Channel that carries received words into the receiver.
interface mdr_in_if;
	logic       valid;
	logic       ready;
	logic [8:0] rx_word;
	logic [7:0] pending_tx_length;

	modport source(output valid, output rx_word, output pending_tx_length, input ready);
	modport sink(input valid, input rx_word, input pending_tx_length, output ready);
endinterface

// ===== rtl/mdr_out_if.sv =====
// Channel that carries the per-word results out of the receiver.
interface mdr_out_if;
	logic       valid;
	logic       ready;
	logic       forward_valid;
	logic [8:0] forward_word;
	logic [2:0] reply_kind;
	logic [7:0] reply_length;
	logic       message_good;
	logic       message_bad;

	modport source(output valid, output forward_valid, output forward_word,
		output reply_kind, output reply_length, output message_good,
		output message_bad, input ready);
	modport sink(input valid, input forward_valid, input forward_word,
		input reply_kind, input reply_length, input message_good,
		input message_bad, output ready);
endinterface

// ===== rtl/mdr_cfg_if.sv =====
// Write channel for the device id register.
interface mdr_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] device_id;

	modport source(output valid, output device_id, input ready);
	modport sink(input valid, input device_id, output ready);
endinterface

// ===== rtl/mdr_in_stage.sv =====
// Input register stage that holds one received word for the decoder.
module mdr_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mdr_pkg::in_item_t   in_item,
	output logic                in_ready,
	input  logic                take,
	output logic                valid_s1,
	output mdr_pkg::in_item_t   item_s1
);

	// The stage refills whenever it is empty or its word moves on.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/mdr_protocol.sv =====
// Protocol state, per-word decode and the result register.
module mdr_protocol (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mdr_pkg::ID_W-1:0]     device_id,
	input  logic                         valid_s1,
	input  mdr_pkg::in_item_t            item_s1,
	output logic                         take,
	input  logic                         out_ready,
	output logic                         valid_s2,
	output mdr_pkg::out_item_t           result_s2
);

	logic [mdr_pkg::PHASE_W-1:0] phase_q, phase_d, phase_now;
	logic [mdr_pkg::BYTE_W-1:0]  sum_q, sum_d, sum_add;
	logic [mdr_pkg::COUNT_W-1:0] count_q, count_d, count_inc;
	logic [mdr_pkg::LEN_W-1:0]   len_q, len_d;
	logic                        bcast_q, bcast_d;
	logic [mdr_pkg::WORD_W-1:0]  w;
	mdr_pkg::out_item_t          res;
	logic                        advance;

	assign advance = !valid_s2 || out_ready;
	assign take    = advance;
	assign w       = item_s1.rx_word;

	assign sum_add   = sum_q + w[mdr_pkg::BYTE_W-1:0];
	assign count_inc = count_q + 6'd1;

	always_comb begin
		// A start word always drops back to listening before decode.
		phase_now = w[mdr_pkg::WORD_W-1] ? mdr_pkg::PHASE_LISTEN : phase_q;
		phase_d   = phase_now;
		sum_d     = sum_q;
		count_d   = count_q;
		len_d     = len_q;
		bcast_d   = bcast_q;
		res       = '0;
		case (phase_now)
			mdr_pkg::PHASE_POLL: begin
				if (w == {mdr_pkg::PREFIX_SELECT, device_id}) begin
					if (item_s1.pending_tx_length == '0) begin
						res.reply_kind   = mdr_pkg::KIND_EMPTY;
						res.reply_length = mdr_pkg::ONE_BYTE;
					end else begin
						res.reply_kind   = mdr_pkg::KIND_SEND;
						res.reply_length = item_s1.pending_tx_length;
					end
					phase_d = mdr_pkg::PHASE_LISTEN;
				end
			end
			mdr_pkg::PHASE_RECEIVE: begin
				sum_d   = sum_add;
				count_d = count_inc;
				if (count_inc == mdr_pkg::COUNT_LENGTH) begin
					len_d             = w[mdr_pkg::LEN_W-1:0];
					res.forward_valid = 1'b1;
					res.forward_word  = w;
				end else if (count_inc == ({1'b0, len_q} + mdr_pkg::COUNT_EXTRA)) begin
					if (sum_add == '0) begin
						res.message_good = 1'b1;
						if (!bcast_q) begin
							res.reply_kind   = mdr_pkg::KIND_ACK;
							res.reply_length = mdr_pkg::ONE_BYTE;
						end
					end else begin
						res.message_bad = 1'b1;
						if (!bcast_q) begin
							res.reply_kind   = mdr_pkg::KIND_NACK;
							res.reply_length = mdr_pkg::ONE_BYTE;
						end
					end
					phase_d = mdr_pkg::PHASE_LISTEN;
				end else begin
					res.forward_valid = 1'b1;
					res.forward_word  = w;
				end
			end
			default: begin
				if (w == {mdr_pkg::PREFIX_ADDR, device_id} || w == mdr_pkg::BROADCAST_WORD) begin
					phase_d           = mdr_pkg::PHASE_RECEIVE;
					count_d           = mdr_pkg::COUNT_START;
					sum_d             = w[mdr_pkg::BYTE_W-1:0];
					bcast_d           = (w == mdr_pkg::BROADCAST_WORD);
					res.forward_valid = 1'b1;
					res.forward_word  = w;
				end else if (w == {mdr_pkg::PREFIX_POLL, device_id}) begin
					phase_d = mdr_pkg::PHASE_POLL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mdr_pkg::PHASE_LISTEN;
			sum_q    <= '0;
			count_q  <= '0;
			len_q    <= '0;
			bcast_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_d;
				sum_q   <= sum_d;
				count_q <= count_d;
				len_q   <= len_d;
				bcast_q <= bcast_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= res;
		end
	end

endmodule

// ===== rtl/multidrop_bus_device_receiver_top.sv =====
// Top level of the device-side receiver for a 9-bit multidrop serial bus.
//
// Channels: rx takes one received 9-bit word together with the length of the
// next queued outgoing message; a transfer happens on a clock edge where
// valid and ready are both high. tx delivers exactly one result per accepted
// word: the forwarded word (if any), the reply request and the end-of-message
// good/bad pulses. cfg writes the 7-bit device id; it is always ready and must
// only be used while no word is in flight.
// A word accepted on rx passes the input register, then the decode and result
// register, before it appears on tx. Throughput is one word per cycle while tx
// does not stall; the per-word state update (phase, checksum, word count) is a
// single short step that closes between the two registers.
// Reset (arst_n low) empties both stages, returns the protocol to listening
// with cleared checksum and counters, and sets the device id to 10.
// When the consumer on tx stalls, the result register holds its transfer and
// the input register keeps one more word; rx.ready falls only when both are
// full, so no word is lost or repeated.
module multidrop_bus_device_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	mdr_in_if.sink     rx,
	mdr_out_if.source  tx,
	mdr_cfg_if.sink    cfg
);

	logic [mdr_pkg::ID_W-1:0] device_id_q;
	mdr_pkg::in_item_t        in_item;
	mdr_pkg::in_item_t        item_s1;
	mdr_pkg::out_item_t       result_s2;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     take;

	// The id register accepts a write in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= mdr_pkg::DEVICE_ID_RESET;
		end else if (cfg.valid) begin
			device_id_q <= cfg.device_id;
		end
	end

	assign in_item.rx_word           = rx.rx_word;
	assign in_item.pending_tx_length = rx.pending_tx_length;

	// Stage one: register the incoming word.
	mdr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_item  (in_item),
		.in_ready (rx.ready),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Stage two: decode against the protocol state and register the result.
	mdr_protocol u_protocol (
		.clk       (clk),
		.arst_n    (arst_n),
		.device_id (device_id_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.out_ready (tx.ready),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2)
	);

	assign tx.valid         = valid_s2;
	assign tx.forward_valid = result_s2.forward_valid;
	assign tx.forward_word  = result_s2.forward_word;
	assign tx.reply_kind    = result_s2.reply_kind;
	assign tx.reply_length  = result_s2.reply_length;
	assign tx.message_good  = result_s2.message_good;
	assign tx.message_bad   = result_s2.message_bad;

endmodule
